### hw/rtl/integer_to_ascii_formatter_core_defines.svh
// assertion helpers for the formatter checker
`ifndef INTEGER_TO_ASCII_FORMATTER_CORE_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_CORE_DEFINES_SVH

// concurrent assertion on an explicit clock and active-low reset
`define ITAF_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("itaf check failed");

// same, on the block clock and reset
`define ITAF_ASSERT(lbl, prop) \
  `ITAF_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

### hw/rtl/itaf_pkg.sv
package itaf_pkg;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned CHAR_W     = 7;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned NUM_DIGITS = 10;
  localparam int unsigned ROW_W      = NUM_DIGITS * DIGIT_W;
  localparam int unsigned BIT_CNT_W  = $clog2(VALUE_W);
  localparam int unsigned REM_W      = $clog2(NUM_DIGITS + 1);

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] ASCII_NINE  = 7'h39;
  localparam logic [CHAR_W-1:0] ASCII_A     = 7'h41;
  localparam logic [CHAR_W-1:0] ASCII_F     = 7'h46;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'h2D;

  localparam logic [DIGIT_W-1:0] DEC_BASE     = 4'd10;
  localparam logic [DIGIT_W-1:0] DABBLE_LIMIT = 4'd5;
  localparam logic [DIGIT_W-1:0] DABBLE_BIAS  = 4'd3;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_DABBLE,
    CELL_EMIT
  } cell_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } itaf_state_e;

  typedef struct packed {
    cell_op_e           op;
    logic               lsb;
    logic [ROW_W-1:0]   load;
  } row_ctrl_t;

  typedef struct packed {
    logic               valid;
    logic [CHAR_W-1:0]  character;
    logic               last;
  } char_push_t;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DEC_BASE) begin
      c = ASCII_ZERO + CHAR_W'(d);
    end else begin
      c = ASCII_A + CHAR_W'(d - DEC_BASE);
    end
    return c;
  endfunction

endpackage

### hw/rtl/itaf_in_if.sv
interface itaf_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [itaf_pkg::VALUE_W-1:0] value;
  logic                                hex_mode;

  modport source (output valid, output value, output hex_mode, input ready);
  modport sink   (input valid, input value, input hex_mode, output ready);
endinterface

### hw/rtl/itaf_out_if.sv
interface itaf_out_if;
  logic                          valid;
  logic                          ready;
  logic [itaf_pkg::CHAR_W-1:0]   character;
  logic                          last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

### hw/rtl/integer_to_ascii_formatter_core.sv
// channel  dir  beat fields        handshake
// in_i     in   value, hex_mode    valid/ready
// out_o    out  character, last    valid/ready
//
// one value at a time; in_i.ready is high only between runs
// decimal: a load, then double-dabble steps through the digit cells, one per value bit,
//   then leading zeros are dropped (one digit is always kept), then an optional minus
//   sign and one character per cycle while out_o takes them
// hex: raw bits loaded, leading zeros dropped, one digit per cycle while out_o takes them
// out_o stalls hold the sign and digit emission in place; reset returns to idle with no beat pending
module integer_to_ascii_formatter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  itaf_in_if.sink     in_i,
  itaf_out_if.source  out_o
);
  import itaf_pkg::*;

  row_ctrl_t          row;
  char_push_t         push;
  logic               out_free;
  logic [DIGIT_W-1:0] digit [NUM_DIGITS];
  logic               carry [NUM_DIGITS];

  logic               out_valid_q;
  logic [CHAR_W-1:0]  out_char_q;
  logic               out_last_q;

  assign out_free = !out_valid_q || out_o.ready;

  itaf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .value_i     (in_i.value),
    .hex_mode_i  (in_i.hex_mode),
    .out_free_i  (out_free),
    .top_digit_i (digit[NUM_DIGITS-1]),
    .row_o       (row),
    .push_o      (push)
  );

  // cell 0 holds the least significant digit
  for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_cell
    logic [DIGIT_W-1:0] lower_digit;
    logic               lower_carry;
    if (g == 0) begin : g_first
      assign lower_digit = '0;
      assign lower_carry = row.lsb;
    end else begin : g_rest
      assign lower_digit = digit[g-1];
      assign lower_carry = carry[g-1];
    end
    itaf_digit_cell u_cell (
      .clk_i         (clk_i),
      .op_i          (row.op),
      .load_i        (row.load[g*DIGIT_W +: DIGIT_W]),
      .lower_digit_i (lower_digit),
      .carry_i       (lower_carry),
      .digit_o       (digit[g]),
      .carry_o       (carry[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push.valid) begin
      out_char_q <= push.character;
      out_last_q <= push.last;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.character = out_char_q;
  assign out_o.last      = out_last_q;

endmodule

### hw/rtl/itaf_digit_cell.sv
module itaf_digit_cell (
  input  logic                          clk_i,
  input  itaf_pkg::cell_op_e            op_i,
  input  logic [itaf_pkg::DIGIT_W-1:0]  load_i,
  input  logic [itaf_pkg::DIGIT_W-1:0]  lower_digit_i,
  input  logic                          carry_i,
  output logic [itaf_pkg::DIGIT_W-1:0]  digit_o,
  output logic                          carry_o
);
  import itaf_pkg::*;

  logic [DIGIT_W-1:0] digit_q, digit_d;
  logic [DIGIT_W-1:0] adj;

  // add-3 correction before each doubling
  assign adj     = (digit_q >= DABBLE_LIMIT) ? digit_q + DABBLE_BIAS : digit_q;
  assign carry_o = adj[DIGIT_W-1];
  assign digit_o = digit_q;

  always_comb begin
    case (op_i)
      CELL_HOLD:   digit_d = digit_q;
      CELL_LOAD:   digit_d = load_i;
      CELL_DABBLE: digit_d = {adj[DIGIT_W-2:0], carry_i};
      CELL_EMIT:   digit_d = lower_digit_i;
      default:     digit_d = digit_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

endmodule

### hw/rtl/itaf_ctrl.sv
module itaf_ctrl (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [itaf_pkg::VALUE_W-1:0] value_i,
  input  logic                                hex_mode_i,
  input  logic                                out_free_i,
  input  logic [itaf_pkg::DIGIT_W-1:0]        top_digit_i,
  output itaf_pkg::row_ctrl_t                 row_o,
  output itaf_pkg::char_push_t                push_o
);
  import itaf_pkg::*;

  itaf_state_e          state_q, state_d;
  logic [VALUE_W-1:0]   bin_q, bin_d;
  logic [BIT_CNT_W-1:0] bit_cnt_q, bit_cnt_d;
  logic [REM_W-1:0]     rem_q, rem_d;
  logic                 sign_q, sign_d;

  logic [VALUE_W-1:0]   raw;
  logic [VALUE_W-1:0]   mag;
  logic                 accept;
  logic                 skip;
  logic                 final_digit;

  assign raw         = value_i;
  assign mag         = raw[VALUE_W-1] ? ('0 - raw) : raw;
  assign accept      = in_valid_i && (state_q == ST_IDLE);
  // drop leading zeros but always keep one digit
  assign skip        = (top_digit_i == '0) && (rem_q > REM_W'(1));
  assign final_digit = (rem_q == REM_W'(1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = hex_mode_i ? ST_SKIP : ST_CONV;
        end
      end
      ST_CONV: begin
        if (bit_cnt_q == BIT_CNT_W'(VALUE_W - 1)) begin
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (!skip) begin
          state_d = sign_q ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (out_free_i) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free_i && final_digit) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    row_o.op   = CELL_HOLD;
    row_o.lsb  = bin_q[VALUE_W-1];
    row_o.load = hex_mode_i ? ROW_W'(raw) : '0;
    push_o.valid     = 1'b0;
    push_o.character = digit_to_ascii(top_digit_i);
    push_o.last      = final_digit;
    bin_d     = bin_q;
    bit_cnt_d = bit_cnt_q;
    rem_d     = rem_q;
    sign_d    = sign_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          row_o.op  = CELL_LOAD;
          bin_d     = mag;
          bit_cnt_d = '0;
          rem_d     = REM_W'(NUM_DIGITS);
          sign_d    = !hex_mode_i && raw[VALUE_W-1];
        end
      end
      ST_CONV: begin
        row_o.op  = CELL_DABBLE;
        bin_d     = {bin_q[VALUE_W-2:0], 1'b0};
        bit_cnt_d = bit_cnt_q + BIT_CNT_W'(1);
      end
      ST_SKIP: begin
        if (skip) begin
          row_o.op = CELL_EMIT;
          rem_d    = rem_q - REM_W'(1);
        end
      end
      ST_SIGN: begin
        push_o.valid     = out_free_i;
        push_o.character = ASCII_MINUS;
        push_o.last      = 1'b0;
        if (out_free_i) begin
          sign_d = 1'b0;
        end
      end
      ST_EMIT: begin
        if (out_free_i) begin
          push_o.valid = 1'b1;
          row_o.op     = CELL_EMIT;
          rem_d        = rem_q - REM_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      bit_cnt_q <= '0;
      rem_q     <= '0;
      sign_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      bit_cnt_q <= bit_cnt_d;
      rem_q     <= rem_d;
      sign_q    <= sign_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
  end

endmodule

### hw/rtl/itaf_checker.sv
`include "integer_to_ascii_formatter_core_defines.svh"

module itaf_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [itaf_pkg::CHAR_W-1:0]  out_char_i,
  input logic                         out_last_i
);
  import itaf_pkg::*;

  logic [REM_W-1:0] run_cnt_q;
  logic             out_beat;

  assign out_beat = out_valid_i && out_ready_i;

  // non-last beats seen in the current run
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_cnt_q <= '0;
    end else if (out_beat) begin
      run_cnt_q <= out_last_i ? '0 : run_cnt_q + REM_W'(1);
    end
  end

  `ITAF_ASSERT(a_no_accept_mid_run, (out_valid_i && !out_last_i) |-> !in_ready_i)

  `ITAF_ASSERT(a_char_legal, out_valid_i |-> ((out_char_i >= ASCII_ZERO && out_char_i <= ASCII_NINE) || (out_char_i >= ASCII_A && out_char_i <= ASCII_F) || out_char_i == ASCII_MINUS))

  `ITAF_ASSERT(a_minus_not_last, (out_valid_i && out_char_i == ASCII_MINUS) |-> !out_last_i)

  `ITAF_ASSERT(a_run_length, (out_beat && !out_last_i) |-> (run_cnt_q < REM_W'(NUM_DIGITS)))

  `ITAF_ASSERT(a_out_hold, (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_char_i)))

endmodule

bind integer_to_ascii_formatter_core itaf_checker u_itaf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_char_i  (out_o.character),
  .out_last_i  (out_o.last)
);
